>>> rtl/core/device_presence_tracker_macros.svh
// ----------------------------------------------------------------------------
// Device presence tracker assertion macros
// Concurrent assertion wrappers, clocked on i_clk; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DEVICE_PRESENCE_TRACKER_MACROS_SVH
`define DEVICE_PRESENCE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property while out of reset
`define DPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every edge, reset included
`define DPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define DPT_ASSERT(label, prop, msg)
`define DPT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> rtl/core/dpt_pkg.sv
// ----------------------------------------------------------------------------
// Device presence tracker package
// Sizes, item codes and the controller-to-datapath command type.
// ----------------------------------------------------------------------------
package dpt_pkg;

    localparam int MAX_DEVICES = 16;
    localparam int COUNT_W     = $clog2(MAX_DEVICES + 1);
    localparam int KIND_W      = 3;
    localparam int ADDR_W      = 48;
    localparam int RSSI_W      = 8;
    localparam int CTR_W       = 16;
    localparam int PRES_W      = 2;

    localparam logic [CTR_W-1:0] LIMIT_RESET = CTR_W'(20);

    typedef enum logic [KIND_W-1:0] {
        KIND_SCAN   = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_TICK   = 3'd3,
        KIND_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [PRES_W-1:0] {
        PRES_NOT_TRACKING = 2'd0,
        PRES_ALONE        = 2'd1,
        PRES_NEARBY       = 2'd2
    } t_presence;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;   // capture the input item
        logic exec;   // apply the item to the table and load the result
    } t_cmd;

endpackage

>>> rtl/core/dpt_ctrl.sv
// ----------------------------------------------------------------------------
// Device presence tracker controller
// Sequences capture and execution of one item and owns the result valid.
// ----------------------------------------------------------------------------
`include "device_presence_tracker_macros.svh"

module dpt_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output dpt_pkg::t_cmd o_cmd
);
    import dpt_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the new result
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = w_slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `DPT_ASSERT(a_accept_to_exec, w_accept |=> (r_state == ST_EXEC), "accept not followed by exec")
    `DPT_ASSERT(a_exec_sets_valid, o_cmd.exec |=> o_out_valid, "exec did not raise result valid")
    `DPT_ASSERT(a_exec_no_overwrite, o_cmd.exec |-> (!r_out_valid || i_out_ready),
                "exec would overwrite a pending result")
    `DPT_ASSERT_ALWAYS(a_cmd_exclusive, !(o_cmd.load && o_cmd.exec), "load and exec together")

endmodule

>>> rtl/core/dpt_datapath.sv
// ----------------------------------------------------------------------------
// Device presence tracker datapath
// Item register, device table cells with parallel compare, result register.
// ----------------------------------------------------------------------------
`include "device_presence_tracker_macros.svh"

module dpt_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dpt_pkg::t_cmd                  i_cmd,
    input  logic                           i_cfg_we,
    input  logic [dpt_pkg::CTR_W-1:0]      i_cfg_wdata,
    input  logic [dpt_pkg::KIND_W-1:0]     i_kind,
    input  logic [dpt_pkg::ADDR_W-1:0]     i_address,
    input  logic signed [dpt_pkg::RSSI_W-1:0] i_rssi,
    input  logic signed [dpt_pkg::RSSI_W-1:0] i_threshold,
    output logic                           o_ok,
    output logic                           o_nearby,
    output logic [dpt_pkg::PRES_W-1:0]     o_presence,
    output logic [dpt_pkg::COUNT_W-1:0]    o_entry_count
);
    import dpt_pkg::*;

    // captured item
    logic [KIND_W-1:0]        r_kind;
    logic [ADDR_W-1:0]        r_addr;
    logic signed [RSSI_W-1:0] r_rssi;
    logic signed [RSSI_W-1:0] r_thr;

    logic [CTR_W-1:0]   r_limit;
    logic [COUNT_W-1:0] r_count, n_count;

    // table cells
    logic [ADDR_W-1:0]        r_ent_addr [MAX_DEVICES];
    logic signed [RSSI_W-1:0] r_ent_thr  [MAX_DEVICES];
    logic [CTR_W-1:0]         r_ent_ctr  [MAX_DEVICES];
    logic [ADDR_W-1:0]        n_ent_addr [MAX_DEVICES];
    logic signed [RSSI_W-1:0] n_ent_thr  [MAX_DEVICES];
    logic [CTR_W-1:0]         n_ent_ctr  [MAX_DEVICES];

    // result
    logic               r_ok, n_ok;
    logic               r_nearby, n_nearby;
    logic [PRES_W-1:0]  r_presence, n_presence;

    logic [MAX_DEVICES-1:0] w_valid;
    logic [MAX_DEVICES-1:0] w_match;
    logic [MAX_DEVICES-1:0] w_first;
    logic [MAX_DEVICES-1:0] w_from_hit;
    logic [MAX_DEVICES-1:0] w_strong;
    logic [MAX_DEVICES-1:0] w_absent;
    logic [MAX_DEVICES-1:0] w_append;
    logic                   w_hit;
    logic                   w_full;
    logic                   w_all_absent;

    always_comb begin
        for (int i = 0; i < MAX_DEVICES; i++) begin
            w_valid[i]  = COUNT_W'(i) < r_count;
            w_match[i]  = w_valid[i] && (r_ent_addr[i] == r_addr);
            w_strong[i] = r_rssi >= r_ent_thr[i];
            w_absent[i] = r_ent_ctr[i] > r_limit;
            w_append[i] = COUNT_W'(i) == r_count;
        end
    end

    // lowest matching cell, and every cell at or above it
    assign w_first      = w_match & (~w_match + MAX_DEVICES'(1));
    assign w_hit        = |w_match;
    assign w_from_hit   = w_hit ? ~(w_first - MAX_DEVICES'(1)) : '0;
    assign w_full       = r_count == COUNT_W'(MAX_DEVICES);
    assign w_all_absent = &(w_absent | ~w_valid);

    always_comb begin
        n_count    = r_count;
        n_ok       = 1'b0;
        n_nearby   = 1'b0;
        n_presence = PRES_NOT_TRACKING;
        for (int i = 0; i < MAX_DEVICES; i++) begin
            n_ent_addr[i] = r_ent_addr[i];
            n_ent_thr[i]  = r_ent_thr[i];
            n_ent_ctr[i]  = r_ent_ctr[i];
        end
        case (r_kind)
            KIND_SCAN: begin
                n_ok     = w_hit;
                n_nearby = |(w_first & w_strong);
                for (int i = 0; i < MAX_DEVICES; i++) begin
                    if (w_first[i] && w_strong[i]) begin
                        n_ent_ctr[i] = '0;
                    end
                end
            end
            KIND_ADD: begin
                n_ok = w_hit || !w_full;
                for (int i = 0; i < MAX_DEVICES; i++) begin
                    if (w_first[i] || (!w_hit && w_append[i])) begin
                        n_ent_addr[i] = r_addr;
                        n_ent_thr[i]  = r_thr;
                        n_ent_ctr[i]  = r_limit;
                    end
                end
                if (!w_hit && !w_full) begin
                    n_count = r_count + COUNT_W'(1);
                end
            end
            KIND_REMOVE: begin
                n_ok = w_hit;
                // shift every later cell down over the removed one
                for (int i = 0; i < MAX_DEVICES - 1; i++) begin
                    if (w_from_hit[i]) begin
                        n_ent_addr[i] = r_ent_addr[i+1];
                        n_ent_thr[i]  = r_ent_thr[i+1];
                        n_ent_ctr[i]  = r_ent_ctr[i+1];
                    end
                end
                if (w_hit) begin
                    n_count = r_count - COUNT_W'(1);
                end
            end
            KIND_TICK: begin
                n_ok = 1'b1;
                if (r_count != '0) begin
                    n_presence = w_all_absent ? PRES_ALONE : PRES_NEARBY;
                end
                for (int i = 0; i < MAX_DEVICES; i++) begin
                    if (w_valid[i] && (r_ent_ctr[i] != '1)) begin
                        n_ent_ctr[i] = r_ent_ctr[i] + CTR_W'(1);
                    end
                end
            end
            KIND_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_addr <= i_address;
            r_rssi <= i_rssi;
            r_thr  <= i_threshold;
        end
        if (i_cmd.exec) begin
            r_ok       <= n_ok;
            r_nearby   <= n_nearby;
            r_presence <= n_presence;
            for (int i = 0; i < MAX_DEVICES; i++) begin
                r_ent_addr[i] <= n_ent_addr[i];
                r_ent_thr[i]  <= n_ent_thr[i];
                r_ent_ctr[i]  <= n_ent_ctr[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_limit <= LIMIT_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    assign o_ok          = r_ok;
    assign o_nearby      = r_nearby;
    assign o_presence    = r_presence;
    assign o_entry_count = r_count;

    `DPT_ASSERT(a_count_bound, r_count <= COUNT_W'(MAX_DEVICES), "entry count above table size")
    `DPT_ASSERT(a_count_only_on_exec, !$past(i_cmd.exec) |-> $stable(r_count),
                "entry count changed without exec")
    `DPT_ASSERT(a_first_onehot, $onehot0(w_first), "more than one first match")

endmodule

>>> rtl/core/device_presence_tracker.sv
// ----------------------------------------------------------------------------
// Device presence tracker
// Table of up to MAX_DEVICES device addresses with RSSI thresholds and
// absence counters; scan, add, remove, tick and clear items.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  item      in         i_in_valid / o_in_ready    i_kind i_address i_rssi i_threshold
//  result    out        o_out_valid / i_out_ready  o_ok o_nearby o_presence o_entry_count
//  config    in         i_cfg_we                   i_cfg_wdata (alone limit)
//
//  Each item is captured first, then executed: all table cells compare in
//  parallel and the table and result register update.
//  One item is in flight at a time; the result register lets the next item be
//  captured while a result still waits, execution holds if it is not taken.
//  Reset empties the table and sets the alone limit to 20; no clearing pass.
// ----------------------------------------------------------------------------
module device_presence_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [dpt_pkg::KIND_W-1:0]        i_kind,
    input  logic [dpt_pkg::ADDR_W-1:0]        i_address,
    input  logic signed [dpt_pkg::RSSI_W-1:0] i_rssi,
    input  logic signed [dpt_pkg::RSSI_W-1:0] i_threshold,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_ok,
    output logic                              o_nearby,
    output logic [dpt_pkg::PRES_W-1:0]        o_presence,
    output logic [dpt_pkg::COUNT_W-1:0]       o_entry_count,
    input  logic                              i_cfg_we,
    input  logic [dpt_pkg::CTR_W-1:0]         i_cfg_wdata
);
    import dpt_pkg::*;

    t_cmd w_cmd;

    dpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    dpt_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_kind),
        .i_address     (i_address),
        .i_rssi        (i_rssi),
        .i_threshold   (i_threshold),
        .o_ok          (o_ok),
        .o_nearby      (o_nearby),
        .o_presence    (o_presence),
        .o_entry_count (o_entry_count)
    );

endmodule

>>> dv/device_presence_tracker_test.sv
// ----------------------------------------------------------------------------
// Device presence tracker testbench
// Drives scan, add, remove, tick, clear and spare items through the item
// channel and checks every result against a table predictor kept in step with
// each accepted transfer, or typed values on checked rows. A short directed
// table comes first, then random phases under several alone limits, with random
// idling on both channels and one long result hold-off that backs the block up.
// ----------------------------------------------------------------------------
module device_presence_tracker_test;
    import dpt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
    localparam logic [CTR_W-1:0]  CTR_MAX          = {CTR_W{1'b1}};
    localparam logic [ADDR_W-1:0] ADDR_ZERO        = '0;
    localparam logic [ADDR_W-1:0] ADDR_ONES        = '1;
    localparam logic [ADDR_W-1:0] ADDR_ALT         = 48'h5555_5555_5555;
    localparam int                POOL_MAX         = 24;
    localparam int                PHASES           = 8;
    localparam int                PHASE_ITEMS      = 180;
    localparam int                MAX_REPORTS      = 10;
    localparam int                HOLD_CYCLES      = 200;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
        logic [RSSI_W-1:0] rssi;
        logic [RSSI_W-1:0] threshold;
    } t_item;

    typedef struct packed {
        logic               ok;
        logic               nearby;
        t_presence          presence;
        logic [COUNT_W-1:0] count;
    } t_report;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CHECKED,
        ROW_LIMIT
    } t_row_kind;

    typedef struct packed {
        t_row_kind         what;
        t_item             item;
        t_report           want;
        logic [CTR_W-1:0]  limit;
    } t_plan_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [KIND_W-1:0]        i_kind = '0;
    logic [ADDR_W-1:0]        i_address = '0;
    logic signed [RSSI_W-1:0] i_rssi = '0;
    logic signed [RSSI_W-1:0] i_threshold = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_ok;
    logic                     o_nearby;
    logic [PRES_W-1:0]        o_presence;
    logic [COUNT_W-1:0]       o_entry_count;
    logic                     i_cfg_we = 1'b0;
    logic [CTR_W-1:0]         i_cfg_wdata = '0;

    // Table predictor state
    logic [ADDR_W-1:0] tbl_addr [MAX_DEVICES];
    logic [RSSI_W-1:0] tbl_thr  [MAX_DEVICES];
    logic [CTR_W-1:0]  tbl_ctr  [MAX_DEVICES];
    int                tbl_used = 0;
    logic [CTR_W-1:0]  limit_model = LIMIT_RESET;

    t_report           pending_reports [$];
    t_plan_row         plan [32];
    int                plan_len = 0;
    logic [ADDR_W-1:0] addr_pool [POOL_MAX];
    int                items_sent = 0;
    int                results_seen = 0;
    int                fail_count = 0;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                rx_gap = 0;
    logic              rx_hold = 1'b0;

    device_presence_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_address     (i_address),
        .i_rssi        (i_rssi),
        .i_threshold   (i_threshold),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_nearby      (o_nearby),
        .o_presence    (o_presence),
        .o_entry_count (o_entry_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int find_slot(logic [ADDR_W-1:0] addr);
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_addr[i] == addr) return i;
        end
        return tbl_used;
    endfunction

    // Apply one item to the predicted table and return the report it yields
    function automatic t_report apply_to_table(t_item it);
        t_report r;
        int      idx;
        bit      all_absent;
        r = '{ok: 1'b0, nearby: 1'b0, presence: PRES_NOT_TRACKING, count: '0};
        idx = find_slot(it.address);
        case (it.kind)
            KIND_SCAN: begin
                if (idx < tbl_used) begin
                    r.ok = 1'b1;
                    if ($signed(it.rssi) >= $signed(tbl_thr[idx])) begin
                        tbl_ctr[idx] = '0;
                        r.nearby = 1'b1;
                    end
                end
            end
            KIND_ADD: begin
                if (idx < tbl_used || tbl_used < MAX_DEVICES) begin
                    if (idx == tbl_used) begin
                        tbl_addr[idx] = it.address;
                        tbl_used++;
                    end
                    tbl_thr[idx] = it.threshold;
                    tbl_ctr[idx] = limit_model;
                    r.ok = 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (idx < tbl_used) begin
                    // shift later entries down one place
                    for (int i = idx; i < tbl_used - 1; i++) begin
                        tbl_addr[i] = tbl_addr[i + 1];
                        tbl_thr[i]  = tbl_thr[i + 1];
                        tbl_ctr[i]  = tbl_ctr[i + 1];
                    end
                    tbl_used--;
                    r.ok = 1'b1;
                end
            end
            KIND_TICK: begin
                r.ok = 1'b1;
                if (tbl_used != 0) begin
                    all_absent = 1'b1;
                    for (int i = 0; i < tbl_used; i++) begin
                        if (!(tbl_ctr[i] > limit_model)) all_absent = 1'b0;
                        if (tbl_ctr[i] != CTR_MAX) tbl_ctr[i]++;
                    end
                    r.presence = all_absent ? PRES_ALONE : PRES_NEARBY;
                end
            end
            KIND_CLEAR: begin
                tbl_used = 0;
                r.ok = 1'b1;
            end
            default: begin
            end
        endcase
        r.count = COUNT_W'(tbl_used);
        return r;
    endfunction

    task automatic put_row(t_row_kind what, logic [KIND_W-1:0] kind,
                           logic [ADDR_W-1:0] addr, logic [RSSI_W-1:0] rssi,
                           logic [RSSI_W-1:0] thr, logic ok, logic nearby,
                           t_presence pres, logic [COUNT_W-1:0] count);
        plan[plan_len].what = what;
        plan[plan_len].item = '{kind: kind, address: addr, rssi: rssi, threshold: thr};
        plan[plan_len].want = '{ok: ok, nearby: nearby, presence: pres, count: count};
        plan[plan_len].limit = '0;
        plan_len++;
    endtask

    task automatic put_limit(logic [CTR_W-1:0] value);
        plan[plan_len] = '0;
        plan[plan_len].what = ROW_LIMIT;
        plan[plan_len].limit = value;
        plan_len++;
    endtask

    // Offer one item, hold it until the transfer, then record its report
    task automatic offer(t_item it, bit use_typed, t_report typed);
        t_report predicted;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= it.kind;
        i_address   <= it.address;
        i_rssi      <= it.rssi;
        i_threshold <= it.threshold;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predicted = apply_to_table(it);
        pending_reports.push_back(use_typed ? typed : predicted);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CTR_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_model = value;
    endtask

    always @(posedge i_clk) begin : drive_out_ready
        if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            rx_gap = $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Hold off the result side long enough for the item side to back up
    initial begin : long_hold
        wait (items_sent >= 300);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : check_results
        t_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_reports.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected", results_seen);
            end else begin
                want = pending_reports.pop_front();
                if (o_ok !== want.ok || o_nearby !== want.nearby ||
                    o_presence !== want.presence || o_entry_count !== want.count) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result %0d: expected ok=%0d nearby=%0d pres=%0d count=%0d",
                                 results_seen, want.ok, want.nearby, want.presence,
                                 want.count);
                        $display("result %0d: actual   ok=%0d nearby=%0d pres=%0d count=%0d",
                                 results_seen, o_ok, o_nearby, o_presence, o_entry_count);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_item   it;
        int      counted;
        int      pool_n;
        int      add_pct;
        int      pick;
        logic [CTR_W-1:0] lim;

        // Empty table, unknown addresses, spare kinds
        put_row(ROW_CHECKED, KIND_TICK, ADDR_ZERO, 8'h00, 8'h00, 1, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_CHECKED, KIND_SCAN, ADDR_ZERO, 8'h7F, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_CHECKED, KIND_REMOVE, ADDR_ONES, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_CHECKED, KIND_SPARE_FIRST, ADDR_ONES, 8'hFF, 8'hFF, 0, 0,
                PRES_NOT_TRACKING, 0);
        put_row(ROW_CHECKED, KIND_SPARE_LAST, ADDR_ONES, 8'hFF, 8'hFF, 0, 0,
                PRES_NOT_TRACKING, 0);
        // Extreme addresses and thresholds
        put_row(ROW_CHECKED, KIND_ADD, ADDR_ZERO, 8'h00, 8'h80, 1, 0, PRES_NOT_TRACKING, 1);
        put_row(ROW_CHECKED, KIND_ADD, ADDR_ONES, 8'hFF, 8'h7F, 1, 0, PRES_NOT_TRACKING, 2);
        put_row(ROW_ITEM, KIND_SCAN, ADDR_ONES, 8'h7E, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_SCAN, ADDR_ONES, 8'h7F, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_SCAN, ADDR_ZERO, 8'h80, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_TICK, ADDR_ZERO, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_ADD, ADDR_ZERO, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_REMOVE, ADDR_ZERO, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_CHECKED, KIND_CLEAR, ADDR_ZERO, 8'h00, 8'h00, 1, 0, PRES_NOT_TRACKING, 0);
        // Alone test at a zero limit
        put_limit(16'd0);
        put_row(ROW_ITEM, KIND_ADD, ADDR_ALT, 8'h00, 8'h55, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_TICK, ADDR_ZERO, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_TICK, ADDR_ZERO, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        // Counter saturation just above the largest limit
        put_limit(16'hFFFE);
        put_row(ROW_ITEM, KIND_ADD, ADDR_ALT, 8'h00, 8'hAA, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_TICK, ADDR_ZERO, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_TICK, ADDR_ZERO, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_TICK, ADDR_ZERO, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        // Full-scale limit never reports alone
        put_limit(16'hFFFF);
        put_row(ROW_ITEM, KIND_ADD, ADDR_ALT, 8'h00, 8'h01, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_TICK, ADDR_ZERO, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_row(ROW_ITEM, KIND_REMOVE, ADDR_ALT, 8'h00, 8'h00, 0, 0, PRES_NOT_TRACKING, 0);
        put_limit(LIMIT_RESET);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < plan_len; r++) begin
            if (plan[r].what == ROW_LIMIT)
                write_limit(plan[r].limit);
            else
                offer(plan[r].item, plan[r].what == ROW_CHECKED, plan[r].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       lim = 16'd0;
                1:       lim = 16'd1;
                2:       lim = 16'd3;
                3:       lim = 16'hFFFE;
                4:       lim = CTR_W'($urandom_range(0, 65535));
                5:       lim = 16'hFFFF;
                6:       lim = 16'd2;
                default: lim = LIMIT_RESET;
            endcase
            write_limit(lim);

            // Wide pools overfill the table, narrow ones keep it busy and small
            pool_n  = (phase % 2 == 0) ? POOL_MAX : $urandom_range(3, 12);
            add_pct = (phase % 2 == 0) ? 35 : 20;
            addr_pool[0] = ADDR_ZERO;
            addr_pool[1] = ADDR_ONES;
            for (int i = 2; i < POOL_MAX; i++)
                addr_pool[i] = ADDR_W'({$urandom, $urandom});

            // Last phase runs without idling
            tx_idle_pct = (phase == PHASES - 1 || phase % 3 == 1) ? 0 : $urandom_range(5, 40);
            rx_idle_pct = (phase == PHASES - 1 || phase % 3 == 2) ? 0 : $urandom_range(5, 40);

            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick         = $urandom_range(0, 99);
                it.rssi      = RSSI_W'($urandom_range(0, 255));
                it.threshold = RSSI_W'($urandom_range(0, 255));
                it.address   = addr_pool[$urandom_range(0, pool_n - 1)];
                if (pick < 3) begin
                    it.kind    = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
                    it.address = ADDR_W'({$urandom, $urandom});
                end else if (pick < 5) begin
                    it.kind = KIND_CLEAR;
                end else if (pick < 5 + add_pct) begin
                    it.kind = KIND_ADD;
                end else if (pick < 15 + add_pct) begin
                    it.kind = KIND_REMOVE;
                end else if (pick < 37 + add_pct) begin
                    it.kind = KIND_TICK;
                end else begin
                    it.kind = KIND_SCAN;
                    if ($urandom_range(0, 9) == 0)
                        it.address = ADDR_W'({$urandom, $urandom});
                end
                offer(it, 1'b0, '0);
                if (it.kind < KIND_SPARE_FIRST) counted++;
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_reports.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
